### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL top level
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define BDQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `BDQ_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

### design/bdq_pkg.sv
// ---------------------------------------------------------------------------
// bdq_pkg
// Types, codes and constants of the bounded double-ended queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned COUNT_MAX = 127;

  localparam int unsigned BLOCK_COUNT_DEF = 8;
  localparam int unsigned BLOCK_SIZE_DEF  = 8;
  localparam int unsigned DATA_WIDTH_DEF  = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_READ       = 3'd4,
    FUNC_WRITE      = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_FULL_FRONT = 3'd1,
    STAT_FULL_BACK  = 3'd2,
    STAT_EMPTY      = 3'd3,
    STAT_RANGE      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_data;
    logic [COUNT_W-1:0]  count;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } ctrl_t;

endpackage

`default_nettype wire

### design/bdq_ram.sv
// ---------------------------------------------------------------------------
// bdq_ram
// Generic single-clock RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### design/bdq_ctrl.sv
// ---------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: accept a command, execute it, present the result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl
  import bdq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  output ctrl_t     ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC:  state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o      = 1'b0;
        ctrl_o.load = start_i;
      end
      S_EXEC:  ctrl_o.exec = 1'b1;
      S_DONE:  ctrl_o.emit = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

### design/bdq_dpath.sv
// ---------------------------------------------------------------------------
// bdq_dpath
// Pointers, empty flag, slot store and result formatting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdq_dpath
  import bdq_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int unsigned BLOCK_SIZE  = BLOCK_SIZE_DEF,
  parameter int unsigned DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire ctrl_t ctrl_i,
  input  wire cmd_t  cmd_i,
  output result_t    result_o
);

  localparam int unsigned SLOTS  = BLOCK_COUNT * BLOCK_SIZE;
  localparam int unsigned PTR_W  = $clog2(SLOTS);
  localparam int unsigned HELD_W = PTR_W + 1;
  localparam int unsigned SUM_W  = ((PTR_W > INDEX_W) ? PTR_W : INDEX_W) + 1;
  localparam logic [PTR_W-1:0] START_SLOT = PTR_W'((BLOCK_COUNT / 2) * BLOCK_SIZE);
  localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(SLOTS - 1);

  cmd_t                cmd_q;
  logic [PTR_W-1:0]    front_q, front_d;
  logic [PTR_W-1:0]    back_q, back_d;
  logic                empty_q, empty_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                rd_ok_q, rd_ok_d;

  logic                  we;
  logic [PTR_W-1:0]      waddr;
  logic                  re;
  logic [HELD_W-1:0]     held;
  logic [SUM_W-1:0]      pos;
  logic                  in_range;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;

  assign held     = empty_q ? '0 : HELD_W'(back_q - front_q) + HELD_W'(1);
  assign pos      = SUM_W'(front_q) + SUM_W'(cmd_q.index);
  assign in_range = SUM_W'(cmd_q.index) < SUM_W'(held);
  assign wdata    = DATA_WIDTH'(cmd_q.value);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
    end
    if (ctrl_i.exec) begin
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      empty_q <= 1'b1;
      rd_ok_q <= 1'b0;
    end else if (ctrl_i.exec) begin
      front_q <= front_d;
      back_q  <= back_d;
      empty_q <= empty_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    empty_d  = empty_q;
    status_d = STAT_OK;
    rd_ok_d  = 1'b0;
    we       = 1'b0;
    waddr    = pos[PTR_W-1:0];
    re       = 1'b0;
    case (cmd_q.func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (empty_q) begin
          front_d = START_SLOT;
          back_d  = START_SLOT;
          empty_d = 1'b0;
          we      = 1'b1;
          waddr   = START_SLOT;
        end else if (cmd_q.func == FUNC_PUSH_FRONT) begin
          if (front_q == '0) begin
            status_d = STAT_FULL_FRONT;
          end else begin
            front_d = front_q - PTR_W'(1);
            we      = 1'b1;
            waddr   = front_d;
          end
        end else begin
          if (back_q == LAST_SLOT) begin
            status_d = STAT_FULL_BACK;
          end else begin
            back_d = back_q + PTR_W'(1);
            we     = 1'b1;
            waddr  = back_d;
          end
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (empty_q) begin
          status_d = STAT_EMPTY;
        end else if (front_q == back_q) begin
          // last element leaves: back to the reset state
          empty_d = 1'b1;
          front_d = '0;
          back_d  = '0;
        end else if (cmd_q.func == FUNC_POP_FRONT) begin
          front_d = front_q + PTR_W'(1);
        end else begin
          back_d = back_q - PTR_W'(1);
        end
      end
      FUNC_READ, FUNC_WRITE: begin
        if (!in_range) begin
          status_d = STAT_RANGE;
        end else if (cmd_q.func == FUNC_READ) begin
          re      = 1'b1;
          rd_ok_d = 1'b1;
        end else begin
          we = 1'b1;
        end
      end
      default: status_d = STAT_OK;
    endcase
    we = we & ctrl_i.exec;
    re = re & ctrl_i.exec;
  end

  bdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (pos[PTR_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    result_o           = '0;
    result_o.status    = status_q;
    result_o.read_data = rd_ok_q ? VALUE_W'(rdata) : '0;
    result_o.count     = (HELD_W'(held) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(held);
  end

endmodule

`default_nettype wire

### design/bounded_double_ended_queue.sv
// ---------------------------------------------------------------------------
// bounded_double_ended_queue
// Deque over a linear slot store without wrap-around, one command at a time.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd_i and raise start_i; the beat is taken at a
//   rising edge with start_i high and busy_o low. Functions: push front/back,
//   pop front/back, read or write at front + index.
//   Result channel: done_o is high for exactly one cycle with result_o
//   (status, read_data, count after the operation). The receiver must take
//   it in that cycle; there is no back-pressure.
//   Sequence: an execute state, then the result state. The result is on
//   the ports in the result state, and busy_o drops in the cycle after
//   the result, so a new command is taken only after the previous one has
//   been executed and its result presented.
//   Reset: pointers cleared, deque empty, no result pending. The slot store
//   is not cleared; only written slots are ever read back.
//   The first push into an empty deque lands in the middle block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bounded_double_ended_queue
  import bdq_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int unsigned BLOCK_SIZE  = BLOCK_SIZE_DEF,
  parameter int unsigned DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire cmd_t cmd_i,
  output logic      busy_o,
  output logic      done_o,
  output result_t   result_o
);

  ctrl_t ctrl;

  bdq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .ctrl_o  (ctrl)
  );

  bdq_dpath #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .BLOCK_SIZE  (BLOCK_SIZE),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cmd_i    (cmd_i),
    .result_o (result_o)
  );

  assign done_o = ctrl.emit;

  `BDQ_ASSERT(a_accept_to_done, clk_i, rst_ni, start_i && !busy_o |-> ##2 done_o, "result late")
  `BDQ_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o, "result beat too long")
  `BDQ_ASSERT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o |=> busy_o && !done_o, "not busy")
  `BDQ_ASSERT_NEVER(a_done_idle, clk_i, rst_ni, done_o && !busy_o, "result beat while idle")

endmodule

`default_nettype wire
